// ----- hdl/hcc_pkg.sv -----
package hcc_pkg;

    localparam int TABLE_BITS  = 14;
    localparam int COUNT_WIDTH = 32;
    localparam int MAP_DEPTH   = 1 << TABLE_BITS;
    localparam int EFF_W       = ($clog2(TABLE_BITS + 1) > 4) ? $clog2(TABLE_BITS + 1) : 4;

    localparam int HASH_W      = 14;
    localparam int TOTAL_W     = 32;
    localparam int MODE_W      = 2;
    localparam int BITS_W      = 4;
    localparam int ACTION_W    = 2;
    localparam int BYTE_W      = 8;
    localparam int CFG_DATA_W  = 4;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 80;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [63:0] FNV_MULT  = 64'h0000_0100_0000_01b3;
    localparam logic [63:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;

    localparam logic [ACTION_W-1:0] ACT_BYTE  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_END   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    localparam logic [MODE_W-1:0] MODE_SUM  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PROD = 2'd1;

    localparam logic REG_HASH_MODE = 1'b0;
    localparam logic REG_HASH_BITS = 1'b1;

    localparam logic [MODE_W-1:0] HASH_MODE_RESET = 2'd2;
    localparam logic [BITS_W-1:0] HASH_BITS_RESET = 4'd8;

    typedef struct packed {
        logic                  is_clear;
        logic [TABLE_BITS-1:0] hash;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_LOOKUP
    } back_state_t;

endpackage

// ----- hdl/hash_collision_counter_unit.sv -----
// Byte and clear transfers: taken at one per cycle while the command queue has room.
// End-of-word result: the command passes the queue, the map read in BK_IDLE and BK_LOOKUP; then m_tvalid rises.
// The seen-map unit reads the bitmap memory in BK_IDLE and writes it in BK_LOOKUP for each word, a
// read-then-write test-and-set; a clear rewrites all 2^TABLE_BITS (16384) bits in BK_CLEAR.
// Reset: synchronous, active low; a clearing pass over all 16384 map bits follows, s_tready low meanwhile.
module hash_collision_counter_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic                              cfg_index,
    input  logic [hcc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [hcc_pkg::S_TDATA_W-1:0]     s_tdata,  // byte_value
    input  logic [hcc_pkg::ACTION_W-1:0]      s_tuser,  // action
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // word hash, is_collision, collision_total, word_total, zero pad
    output logic [hcc_pkg::M_TDATA_W-1:0]     m_tdata
);

    logic                             s_accept;
    logic                             push;
    hcc_pkg::cmd_t                    push_data;
    hcc_pkg::cmd_t                    head;
    logic                             pop;
    logic                             empty;
    logic                             full;
    logic                             init_done;
    logic [hcc_pkg::TABLE_BITS-1:0]   out_hash;
    logic                             out_coll;
    logic [hcc_pkg::COUNT_WIDTH-1:0]  out_coll_total;
    logic [hcc_pkg::COUNT_WIDTH-1:0]  out_word_total;

    assign s_tready = init_done && !full;
    assign s_accept = s_tvalid && s_tready;

    hcc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (s_accept),
        .action     (s_tuser),
        .byte_value (s_tdata[hcc_pkg::BYTE_W-1:0]),
        .push       (push),
        .push_data  (push_data)
    );

    hcc_fifo u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (full)
    );

    hcc_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head           (head),
        .empty          (empty),
        .pop            (pop),
        .init_done      (init_done),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_hash       (out_hash),
        .out_coll       (out_coll),
        .out_coll_total (out_coll_total),
        .out_word_total (out_word_total)
    );

    assign m_tdata = {1'b0,
                      hcc_pkg::TOTAL_W'(out_word_total),
                      hcc_pkg::TOTAL_W'(out_coll_total),
                      out_coll,
                      hcc_pkg::HASH_W'(64'(out_hash))};

endmodule

// ----- hdl/hcc_ram.sv -----
module hcc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16384
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hdl/hcc_fifo.sv -----
module hcc_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  hcc_pkg::cmd_t push_data,
    input  logic          pop,
    output hcc_pkg::cmd_t head,
    output logic          empty,
    output logic          full
);

    hcc_pkg::cmd_t                  entry_reg [hcc_pkg::QUEUE_DEPTH];
    logic [hcc_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [hcc_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [hcc_pkg::QPTR_W:0]       count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (hcc_pkg::QPTR_W+1)'(hcc_pkg::QUEUE_DEPTH));
    assign head  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hdl/hcc_front.sv -----
module hcc_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic                            cfg_index,
    input  logic [hcc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            accept,
    input  logic [hcc_pkg::ACTION_W-1:0]    action,
    input  logic [hcc_pkg::BYTE_W-1:0]      byte_value,
    output logic                            push,
    output hcc_pkg::cmd_t                   push_data
);

    // only the low TABLE_BITS of the 64-bit hash ever reach the output
    localparam logic [hcc_pkg::TABLE_BITS-1:0] BASIS_LOW =
        hcc_pkg::FNV_BASIS[hcc_pkg::TABLE_BITS-1:0];
    localparam logic [hcc_pkg::TABLE_BITS-1:0] PRIME_LOW =
        hcc_pkg::FNV_MULT[hcc_pkg::TABLE_BITS-1:0];

    logic [hcc_pkg::MODE_W-1:0]     hash_mode_reg;
    logic [hcc_pkg::BITS_W-1:0]     hash_bits_reg;
    logic [hcc_pkg::TABLE_BITS-1:0] hash_reg, hash_next;
    logic                           started_reg, started_next;

    logic [hcc_pkg::TABLE_BITS-1:0] start_val;
    logic [hcc_pkg::TABLE_BITS-1:0] cur_hash;
    logic [hcc_pkg::TABLE_BITS-1:0] byte_ext;
    logic [hcc_pkg::TABLE_BITS-1:0] mul_a, mul_b;
    logic [hcc_pkg::EFF_W-1:0]      eff_bits;
    logic [hcc_pkg::EFF_W-1:0]      bits_ext;
    logic [hcc_pkg::TABLE_BITS-1:0] mask;

    always_comb begin
        unique case (hash_mode_reg)
            hcc_pkg::MODE_SUM:  start_val = '0;
            hcc_pkg::MODE_PROD: start_val = hcc_pkg::TABLE_BITS'(1);
            default:            start_val = BASIS_LOW;
        endcase
        cur_hash = started_reg ? hash_reg : start_val;
        byte_ext = hcc_pkg::TABLE_BITS'(byte_value);
    end

    always_comb begin
        bits_ext = hcc_pkg::EFF_W'(hash_bits_reg);
        if (bits_ext == '0) begin
            eff_bits = hcc_pkg::EFF_W'(1);
        end else if (bits_ext > hcc_pkg::EFF_W'(hcc_pkg::TABLE_BITS)) begin
            eff_bits = hcc_pkg::EFF_W'(hcc_pkg::TABLE_BITS);
        end else begin
            eff_bits = bits_ext;
        end
        mask = {hcc_pkg::TABLE_BITS{1'b1}} >> (hcc_pkg::EFF_W'(hcc_pkg::TABLE_BITS) - eff_bits);
    end

    always_comb begin
        mul_a = cur_hash ^ byte_ext;
        mul_b = PRIME_LOW;
        if (hash_mode_reg == hcc_pkg::MODE_PROD) begin
            mul_a = cur_hash;
            mul_b = byte_ext + 1'b1;
        end
    end

    always_comb begin
        hash_next    = hash_reg;
        started_next = started_reg;
        push         = 1'b0;
        push_data    = '{is_clear: 1'b0, hash: cur_hash & mask};
        if (accept) begin
            unique case (action)
                hcc_pkg::ACT_BYTE: begin
                    if (hash_mode_reg == hcc_pkg::MODE_SUM) begin
                        hash_next = cur_hash + byte_ext;
                    end else begin
                        hash_next = hcc_pkg::TABLE_BITS'(mul_a * mul_b);
                    end
                    started_next = 1'b1;
                end
                hcc_pkg::ACT_END: begin
                    push         = 1'b1;
                    started_next = 1'b0;
                end
                hcc_pkg::ACT_CLEAR: begin
                    push               = 1'b1;
                    push_data.is_clear = 1'b1;
                    started_next       = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_mode_reg <= hcc_pkg::HASH_MODE_RESET;
            hash_bits_reg <= hcc_pkg::HASH_BITS_RESET;
            started_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    hcc_pkg::REG_HASH_MODE: hash_mode_reg <= cfg_data[hcc_pkg::MODE_W-1:0];
                    hcc_pkg::REG_HASH_BITS: hash_bits_reg <= cfg_data[hcc_pkg::BITS_W-1:0];
                    default: begin
                    end
                endcase
            end
            started_reg <= started_next;
        end
    end

    always_ff @(posedge aclk) begin
        hash_reg <= hash_next;
    end

endmodule

// ----- hdl/hcc_back.sv -----
module hcc_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  hcc_pkg::cmd_t                       head,
    input  logic                                empty,
    output logic                                pop,
    output logic                                init_done,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [hcc_pkg::TABLE_BITS-1:0]      out_hash,
    output logic                                out_coll,
    output logic [hcc_pkg::COUNT_WIDTH-1:0]     out_coll_total,
    output logic [hcc_pkg::COUNT_WIDTH-1:0]     out_word_total
);

    localparam logic [hcc_pkg::TABLE_BITS-1:0] LAST_ADDR = '1;
    localparam logic [hcc_pkg::COUNT_WIDTH-1:0] COUNT_MAX = '1;

    hcc_pkg::back_state_t state_reg, state_next;

    logic [hcc_pkg::TABLE_BITS-1:0]  addr_reg, addr_next;
    logic [hcc_pkg::COUNT_WIDTH-1:0] coll_cnt_reg, coll_cnt_next;
    logic [hcc_pkg::COUNT_WIDTH-1:0] word_cnt_reg, word_cnt_next;
    logic                            init_done_reg, init_done_next;
    logic                            out_valid_reg, out_valid_next;
    logic                            load_out;

    logic                            ram_wr_en;
    logic [hcc_pkg::TABLE_BITS-1:0]  ram_wr_addr;
    logic                            ram_wr_data;
    logic                            ram_rd_en;
    logic                            ram_rd_data;

    hcc_ram #(
        .WIDTH (1),
        .DEPTH (hcc_pkg::MAP_DEPTH)
    ) u_seen_map (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (head.hash),
        .rd_data (ram_rd_data)
    );

    always_comb begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        coll_cnt_next  = coll_cnt_reg;
        word_cnt_next  = word_cnt_reg;
        init_done_next = init_done_reg;
        out_valid_next = out_valid_reg && !out_ready;
        load_out       = 1'b0;
        pop            = 1'b0;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = addr_reg;
        ram_wr_data    = 1'b0;
        ram_rd_en      = 1'b0;

        unique case (state_reg)
            hcc_pkg::BK_CLEAR: begin
                ram_wr_en = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == LAST_ADDR) begin
                    init_done_next = 1'b1;
                    state_next     = hcc_pkg::BK_IDLE;
                end
            end
            hcc_pkg::BK_IDLE: begin
                if (!empty && (!out_valid_reg || out_ready)) begin
                    pop = 1'b1;
                    if (head.is_clear) begin
                        addr_next     = '0;
                        coll_cnt_next = '0;
                        word_cnt_next = '0;
                        state_next    = hcc_pkg::BK_CLEAR;
                    end else begin
                        ram_rd_en  = 1'b1;
                        addr_next  = head.hash;
                        state_next = hcc_pkg::BK_LOOKUP;
                    end
                end
            end
            hcc_pkg::BK_LOOKUP: begin
                ram_wr_en   = 1'b1;
                ram_wr_data = 1'b1;
                if (ram_rd_data && (coll_cnt_reg != COUNT_MAX)) begin
                    coll_cnt_next = coll_cnt_reg + 1'b1;
                end
                if (word_cnt_reg != COUNT_MAX) begin
                    word_cnt_next = word_cnt_reg + 1'b1;
                end
                load_out       = 1'b1;
                out_valid_next = 1'b1;
                state_next     = hcc_pkg::BK_IDLE;
            end
            default: begin
                state_next = hcc_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= hcc_pkg::BK_CLEAR;
            addr_reg      <= '0;
            coll_cnt_reg  <= '0;
            word_cnt_reg  <= '0;
            init_done_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            coll_cnt_reg  <= coll_cnt_next;
            word_cnt_reg  <= word_cnt_next;
            init_done_reg <= init_done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_hash       <= addr_reg;
            out_coll       <= ram_rd_data;
            out_coll_total <= coll_cnt_next;
            out_word_total <= word_cnt_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign init_done = init_done_reg;

endmodule

// ----- bench/hash_collision_counter_unit_tb.sv -----
`timescale 1ns / 1ps

module hash_collision_counter_unit_tb;
    import hcc_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam logic [MODE_W-1:0]   MODE_FNV   = 2'd2;
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int CLEAR_SETTLE  = MAP_DEPTH + 64;
    localparam int RANDOM_ITEMS  = 1350;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [BYTE_W-1:0]   byte_val;
    } stim_t;

    typedef struct packed {
        logic [HASH_W-1:0]  hash_val;
        logic               collided;
        logic [TOTAL_W-1:0] coll_total;
        logic [TOTAL_W-1:0] word_total;
    } word_report_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic                   cfg_index = 1'b0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic [ACTION_W-1:0]    s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;

    hash_collision_counter_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    // predictor state
    logic [MODE_W-1:0]  cur_mode;
    logic [BITS_W-1:0]  cur_bits;
    logic [63:0]        run_hash;
    logic               word_open;
    bit                 seen_model [0:MAP_DEPTH-1];
    logic [TOTAL_W-1:0] coll_cnt;
    logic [TOTAL_W-1:0] word_cnt;

    stim_t        pend_q[$];
    word_report_t word_report_q[$];

    int n_offered = 0;
    int n_taken   = 0;
    int burst_left = 0;
    int gap_left   = 0;
    int fail_count = 0;
    int cycle_count = 0;
    int rx_hold_reqs = 0;
    int rx_hold_seen = 0;
    int rx_hold_left = 0;
    int rx_mode = 0;
    int rx_mode_left = 0;
    int rx_tick = 0;

    word_report_t want;
    word_report_t got;

    task automatic clear_tracker();
        foreach (seen_model[i]) seen_model[i] = 1'b0;
        coll_cnt  = '0;
        word_cnt  = '0;
        run_hash  = '0;
        word_open = 1'b0;
    endtask

    task automatic absorb_transfer(input logic [ACTION_W-1:0] act, input logic [BYTE_W-1:0] b);
        logic [63:0]  h;
        logic [63:0]  masked;
        int unsigned  nb;
        word_report_t rep;
        if (word_open) h = run_hash;
        else if (cur_mode == MODE_SUM) h = 64'd0;
        else if (cur_mode == MODE_PROD) h = 64'd1;
        else h = FNV_BASIS;
        case (act)
            ACT_BYTE: begin
                case (cur_mode)
                    MODE_SUM:  h = h + {56'd0, b};
                    MODE_PROD: h = h * ({56'd0, b} + 64'd1);
                    default:   h = (h ^ {56'd0, b}) * FNV_MULT;
                endcase
                run_hash  = h;
                word_open = 1'b1;
            end
            ACT_END: begin
                nb = (cur_bits == 0) ? 1 : ((cur_bits > TABLE_BITS) ? TABLE_BITS : cur_bits);
                masked = h & ((64'd1 << nb) - 64'd1);
                rep.hash_val = masked[HASH_W-1:0];
                if (seen_model[masked[TABLE_BITS-1:0]]) begin
                    rep.collided = 1'b1;
                    if (coll_cnt != '1) coll_cnt = coll_cnt + 1'b1;
                end else begin
                    rep.collided = 1'b0;
                    seen_model[masked[TABLE_BITS-1:0]] = 1'b1;
                end
                if (word_cnt != '1) word_cnt = word_cnt + 1'b1;
                rep.coll_total = coll_cnt;
                rep.word_total = word_cnt;
                word_report_q.insert(word_report_q.size(), rep);
                run_hash  = '0;
                word_open = 1'b0;
            end
            ACT_CLEAR: clear_tracker();
            default: ;
        endcase
    endtask

    // input side: predict on every accepted transfer
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            n_taken = n_taken + 1;
            absorb_transfer(s_tuser, s_tdata);
        end
    end

    // result side
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got.hash_val   = m_tdata[13:0];
            got.collided   = m_tdata[14];
            got.coll_total = m_tdata[46:15];
            got.word_total = m_tdata[78:47];
            if (word_report_q.size() == 0) begin
                fail_count = fail_count + 1;
                if (fail_count <= REPORT_MAX)
                    $display("unexpected result: hash %0d coll %0d ctot %0d wtot %0d",
                             got.hash_val, got.collided, got.coll_total, got.word_total);
            end else begin
                want = word_report_q.pop_front();
                if (got.hash_val !== want.hash_val || got.collided !== want.collided ||
                    got.coll_total !== want.coll_total || got.word_total !== want.word_total) begin
                    fail_count = fail_count + 1;
                    if (fail_count <= REPORT_MAX)
                        $display("mismatch: hash %0d/%0d coll %0d/%0d ctot %0d/%0d wtot %0d/%0d",
                                 want.hash_val, got.hash_val, want.collided, got.collided,
                                 want.coll_total, got.coll_total,
                                 want.word_total, got.word_total);
                end
            end
        end
    end

    // sender: bursts with random gaps
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (n_taken == n_offered) begin
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                s_tvalid <= 1'b0;
            end else if (pend_q.size() > 0) begin
                stim_t nxt;
                nxt = pend_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= nxt.action;
                s_tdata  <= nxt.byte_val;
                n_offered = n_offered + 1;
                if (burst_left > 1) begin
                    burst_left = burst_left - 1;
                end else begin
                    burst_left = ($urandom_range(0, 9) == 0) ? 100 : $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern, plus long hold on request
    always @(negedge aclk) begin
        rx_tick = rx_tick + 1;
        if (rx_hold_seen != rx_hold_reqs) begin
            rx_hold_seen = rx_hold_reqs;
            rx_hold_left = 600;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left = rx_hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(32, 400);
            end else begin
                rx_mode_left = rx_mode_left - 1;
            end
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 1) == 1);
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ((rx_tick % 7) < 3);
            endcase
        end
    end

    always @(posedge aclk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic push_item(input logic [ACTION_W-1:0] act, input logic [BYTE_W-1:0] b);
        stim_t it;
        it.action   = act;
        it.byte_val = b;
        pend_q.insert(pend_q.size(), it);
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] mode_data,
                              input logic [CFG_DATA_W-1:0] bits_data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_HASH_MODE;
        cfg_data  <= mode_data;
        cur_mode  = mode_data[MODE_W-1:0];
        @(negedge aclk);
        cfg_index <= REG_HASH_BITS;
        cfg_data  <= bits_data;
        cur_bits  = bits_data[BITS_W-1:0];
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // let queued items drain, then give the block time to go idle
    task automatic finish_phase(input bit had_clear);
        while (pend_q.size() != 0 || s_tvalid || word_report_q.size() != 0)
            @(posedge aclk);
        repeat (had_clear ? CLEAR_SETTLE : 16) @(posedge aclk);
    endtask

    initial begin
        int total;
        int phase_no;
        int n;
        int cnt;
        int r;
        int len;
        bit narrow;
        bit clr_done;
        logic [CFG_DATA_W-1:0] mdata;
        logic [CFG_DATA_W-1:0] bdata;

        cur_mode = HASH_MODE_RESET;
        cur_bits = HASH_BITS_RESET;
        clear_tracker();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: empty words, ignored code, clear
        push_item(ACT_END, 8'hFF);
        push_item(ACT_BYTE, 8'h00);
        push_item(ACT_BYTE, 8'hFF);
        push_item(ACT_END, 8'h00);
        push_item(ACT_END, 8'h5A);
        push_item(ACT_UNUSED, 8'hA5);
        push_item(ACT_CLEAR, 8'h3C);
        push_item(ACT_END, 8'h00);
        finish_phase(1'b1);

        // sum, full width; leave a word open across the mode change
        set_config({2'b00, MODE_SUM}, 4'd14);
        push_item(ACT_BYTE, 8'hFF);
        push_item(ACT_BYTE, 8'hFF);
        push_item(ACT_END, 8'h00);
        push_item(ACT_BYTE, 8'h01);
        push_item(ACT_END, 8'hFF);
        push_item(ACT_BYTE, 8'h10);
        finish_phase(1'b0);

        // product, zero bits taken as one
        set_config({2'b00, MODE_PROD}, 4'd0);
        push_item(ACT_BYTE, 8'h02);
        push_item(ACT_END, 8'h00);
        finish_phase(1'b0);

        // spare mode code, bits above table size
        set_config(4'hF, 4'd15);
        push_item(ACT_BYTE, 8'h80);
        push_item(ACT_END, 8'h00);
        push_item(ACT_END, 8'h00);
        finish_phase(1'b0);

        set_config({2'b01, MODE_FNV}, 4'd1);
        push_item(ACT_BYTE, 8'h7F);
        push_item(ACT_END, 8'h00);
        finish_phase(1'b0);

        total    = 0;
        phase_no = 0;
        while (total < RANDOM_ITEMS) begin
            mdata = CFG_DATA_W'($urandom_range(0, 15));
            r = $urandom_range(0, 9);
            if (r == 0) bdata = 4'd0;
            else if (r == 1) bdata = 4'd14;
            else if (r == 2) bdata = 4'd15;
            else if (r == 3) bdata = CFG_DATA_W'($urandom_range(0, 15));
            else bdata = CFG_DATA_W'($urandom_range(1, 6));
            set_config(mdata, bdata);
            if (phase_no == 1) rx_hold_reqs = rx_hold_reqs + 1;

            n        = $urandom_range(60, 180);
            cnt      = 0;
            clr_done = 1'b0;
            while (cnt < n) begin
                r = $urandom_range(0, 99);
                if (r < 88) begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24)
                                                       : $urandom_range(0, 5);
                    narrow = $urandom_range(0, 1);
                    for (int j = 0; j < len; j++)
                        push_item(ACT_BYTE, narrow ? BYTE_W'($urandom_range(0, 3))
                                                   : BYTE_W'($urandom_range(0, 255)));
                    push_item(ACT_END, BYTE_W'($urandom_range(0, 255)));
                    cnt = cnt + len + 1;
                end else if (r < 93) begin
                    push_item(ACT_UNUSED, BYTE_W'($urandom_range(0, 255)));
                    cnt = cnt + 1;
                end else if (r < 98) begin
                    push_item(ACT_BYTE, BYTE_W'($urandom_range(0, 255)));
                    cnt = cnt + 1;
                end else if (!clr_done && $urandom_range(0, 3) == 0) begin
                    push_item(ACT_CLEAR, BYTE_W'($urandom_range(0, 255)));
                    clr_done = 1'b1;
                    cnt = cnt + 1;
                end else begin
                    push_item(ACT_END, BYTE_W'($urandom_range(0, 255)));
                    cnt = cnt + 1;
                end
            end
            // sometimes leave a word unfinished for the next settings
            if ($urandom_range(0, 2) == 0) begin
                len = $urandom_range(1, 3);
                for (int j = 0; j < len; j++)
                    push_item(ACT_BYTE, BYTE_W'($urandom_range(0, 255)));
                cnt = cnt + len;
            end
            total    = total + cnt;
            phase_no = phase_no + 1;
            finish_phase(clr_done);
        end

        repeat (64) @(posedge aclk);
        if (word_report_q.size() != 0) begin
            fail_count = fail_count + 1;
            $display("%0d results never arrived", word_report_q.size());
        end
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
